[hdl/ntage_pkg.sv]
// ----------------------------------------------------------------------------
// Neighbour table aging package
// Shared codes, widths and the sequencer state type for the neighbour table.
// ----------------------------------------------------------------------------
package ntage_pkg;

  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int RAND_W   = 32;
  localparam int THR_W    = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCNT_W   = 5;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;

  localparam logic [KIND_W-1:0] KIND_HEARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PICK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEARD_RD,
    S_HEARD_CHK,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_PICK_DIV,
    S_PICK_RD,
    S_PICK_CHK
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

[hdl/neighbour_table_aging_top.sv]
// ----------------------------------------------------------------------------
// Neighbour table with aging
// Keeps neighbour ids in insertion order with their last-heard second.
// ----------------------------------------------------------------------------
// The input channel carries one transaction per command: heard (look up the
// sender, append it if absent and the table has room, stamp its time), sweep
// (drop every entry older than the threshold and compact the rest) and pick
// (return the entry at the random word modulo the entry count). Every input
// transaction yields exactly one output transaction. The threshold is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while the
// block is idle, and the block itself leaves this unchecked.
// The table sits in one memory with a registered read port, walked by a small
// sequencer one entry at a time. After a command that needs no scan (empty
// table or unused kind), out_valid rises in the cycle after acceptance. A pick
// on a filled table waits for the bit-serial modulo unit that handles one
// dividend bit per cycle. Only one transaction is in work at a time; in_ready
// is high while the sequencer is idle and the output register is empty, so the
// next input transaction is taken in the cycle after the result is accepted.
// A stalled receiver holds the result and blocks the input. Reset empties the
// table and sets the threshold to ten seconds.
// ----------------------------------------------------------------------------
module neighbour_table_aging_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ntage_pkg::THR_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ntage_pkg::KIND_W-1:0]  in_kind,
  input  logic [ntage_pkg::ID_W-1:0]    in_node_id,
  input  logic [ntage_pkg::TIME_W-1:0]  in_now_seconds,
  input  logic [ntage_pkg::RAND_W-1:0]  in_random_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntage_pkg::STATUS_W-1:0] out_status,
  output logic [ntage_pkg::ID_W-1:0]    out_picked_id,
  output logic                          out_was_new,
  output logic [ntage_pkg::OCNT_W-1:0]  out_removed_count,
  output logic [ntage_pkg::OCNT_W-1:0]  out_entry_total
);
  import ntage_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [THR_W-1:0]    thr_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       keep_r, keep_nxt;
  logic [CW-1:0]       removed_r, removed_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]     picked_r, picked_nxt;
  logic                was_new_r, was_new_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_picked_r;
  logic                out_was_new_r;
  logic [CW-1:0]       out_removed_r;
  logic [CW-1:0]       out_total_r;

  logic [ID_W-1:0]     ids_mem [TABLE_DEPTH];
  logic [TIME_W-1:0]   time_mem [TABLE_DEPTH];
  logic [ID_W-1:0]     rd_id_r;
  logic [TIME_W-1:0]   rd_time_r;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       mem_raddr;
  logic [ID_W-1:0]     mem_wid;
  logic [TIME_W-1:0]   mem_wtime;

  logic                in_acc;
  logic                out_load;
  logic                is_last;
  logic                has_room;
  logic                expired;
  logic [TIME_W-1:0]   age;
  logic                mod_start;
  mod_status_t         mod_st;
  logic [IW-1:0]       mod_rem;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign is_last  = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign has_room = (cnt_r < CW'(TABLE_DEPTH));
  assign age      = now_r - rd_time_r;
  assign expired  = (age > TIME_W'(thr_r));
  assign mod_start = in_acc && (in_kind == KIND_PICK) && (cnt_r != '0);
  assign mem_raddr = (state_r == S_PICK_RD) ? mod_rem : idx_r;

  ntage_mod_unit #(
    .CNT_W (CW),
    .IDX_W (IW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_random_value),
    .divisor   (cnt_r),
    .status    (mod_st),
    .remainder (mod_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_HEARD: state_nxt = (cnt_r == '0) ? S_IDLE : S_HEARD_RD;
            KIND_SWEEP: state_nxt = (cnt_r == '0) ? S_IDLE : S_SWEEP_RD;
            KIND_PICK:  state_nxt = (cnt_r == '0) ? S_IDLE : S_PICK_DIV;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_HEARD_RD:  state_nxt = S_HEARD_CHK;
      S_HEARD_CHK: begin
        if (rd_id_r == id_r || is_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HEARD_RD;
        end
      end
      S_SWEEP_RD:  state_nxt = S_SWEEP_CHK;
      S_SWEEP_CHK: state_nxt = is_last ? S_IDLE : S_SWEEP_RD;
      S_PICK_DIV:  state_nxt = mod_st.done ? S_PICK_RD : S_PICK_DIV;
      S_PICK_RD:   state_nxt = S_PICK_CHK;
      S_PICK_CHK:  state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // A result is finished when the sequencer returns to idle from a command.
  logic finish;
  always_comb begin
    finish = 1'b0;
    unique case (state_r)
      S_IDLE:      finish = in_acc && (state_nxt == S_IDLE);
      S_HEARD_CHK: finish = (state_nxt == S_IDLE);
      S_SWEEP_CHK: finish = is_last;
      S_PICK_CHK:  finish = 1'b1;
      default:     finish = 1'b0;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    picked_nxt  = picked_r;
    was_new_nxt = was_new_r;
    id_nxt      = id_r;
    now_nxt     = now_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wid     = id_r;
    mem_wtime   = now_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt      = in_node_id;
          now_nxt     = in_now_seconds;
          idx_nxt     = '0;
          keep_nxt    = '0;
          removed_nxt = '0;
          status_nxt  = STATUS_OK;
          was_new_nxt = 1'b0;
          picked_nxt  = '0;
          if (in_kind == KIND_HEARD) begin
            picked_nxt = in_node_id;
            if (cnt_r == '0) begin
              mem_we      = 1'b1;
              mem_waddr   = '0;
              mem_wid     = in_node_id;
              mem_wtime   = in_now_seconds;
              cnt_nxt     = CW'(1);
              was_new_nxt = 1'b1;
            end
          end else if (in_kind == KIND_PICK && cnt_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end
        end
      end
      S_HEARD_CHK: begin
        if (rd_id_r == id_r) begin
          mem_we = 1'b1;
        end else if (is_last) begin
          if (has_room) begin
            mem_we      = 1'b1;
            mem_waddr   = IW'(cnt_r);
            cnt_nxt     = cnt_r + CW'(1);
            was_new_nxt = 1'b1;
          end else begin
            status_nxt = STATUS_FULL;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SWEEP_CHK: begin
        if (expired) begin
          removed_nxt = removed_r + CW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = IW'(keep_r);
          mem_wid   = rd_id_r;
          mem_wtime = rd_time_r;
          keep_nxt  = keep_r + CW'(1);
        end
        if (is_last) begin
          cnt_nxt = expired ? keep_r : keep_r + CW'(1);
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_PICK_CHK: picked_nxt = rd_id_r;
      default: begin
      end
    endcase
  end

  assign out_load = finish;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ids_mem[mem_waddr]  <= mem_wid;
      time_mem[mem_waddr] <= mem_wtime;
    end
    rd_id_r   <= ids_mem[mem_raddr];
    rd_time_r <= time_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THRESHOLD_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
    idx_r     <= idx_nxt;
    keep_r    <= keep_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    picked_r  <= picked_nxt;
    was_new_r <= was_new_nxt;
    id_r      <= id_nxt;
    now_r     <= now_nxt;
    if (out_load) begin
      out_status_r  <= status_nxt;
      out_picked_r  <= picked_nxt;
      out_was_new_r <= was_new_nxt;
      out_removed_r <= removed_nxt;
      out_total_r   <= cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_picked_id     = out_picked_r;
  assign out_was_new       = out_was_new_r;
  assign out_removed_count = OCNT_W'(out_removed_r);
  assign out_entry_total   = OCNT_W'(out_total_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_mod_done_in_pick: assert property (@(posedge clk) disable iff (!rst_n)
    mod_st.done |-> state_r == S_PICK_DIV)
    else $error("modulo result arrived outside a pick");

  a_keep_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP_CHK |-> keep_r <= CW'(idx_r))
    else $error("sweep write pointer passed the read pointer");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind != KIND_SWEEP && in_kind != KIND_HEARD && in_kind != KIND_PICK)
      |=> out_valid)
    else $error("unused command produced no result");

endmodule

[hdl/ntage_mod_unit.sv]
// ----------------------------------------------------------------------------
// Neighbour table serial modulo unit
// Computes a 32-bit word modulo the entry count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ntage_mod_unit #(
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ntage_pkg::RAND_W-1:0] dividend,
  input  logic [CNT_W-1:0]            divisor,
  output ntage_pkg::mod_status_t      status,
  output logic [IDX_W-1:0]            remainder
);
  import ntage_pkg::*;

  localparam int STEP_W = $clog2(RAND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAND_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  assign shifted = {rem_r, dvd_r[RAND_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[RAND_W-2:0], 1'b0};
      rem_nxt  = (shifted >= {1'b0, divisor}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign remainder   = IDX_W'(rem_r);

endmodule

[tb/sv/neighbour_table_aging_check.sv]
// ----------------------------------------------------------------------------
// Neighbour table aging transaction check
// Watches the configuration, input and result channels of the neighbour
// table. It keeps its own copy of the table and the expiry threshold,
// works out the result of every accepted input transaction, and compares
// each accepted result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module neighbour_table_aging_check #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ntage_pkg::THR_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ntage_pkg::KIND_W-1:0]   in_kind,
  input  logic [ntage_pkg::ID_W-1:0]     in_node_id,
  input  logic [ntage_pkg::TIME_W-1:0]   in_now_seconds,
  input  logic [ntage_pkg::RAND_W-1:0]   in_random_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ntage_pkg::STATUS_W-1:0] out_status,
  input  logic [ntage_pkg::ID_W-1:0]     out_picked_id,
  input  logic                           out_was_new,
  input  logic [ntage_pkg::OCNT_W-1:0]   out_removed_count,
  input  logic [ntage_pkg::OCNT_W-1:0]   out_entry_total,
  output int                             mismatch_count,
  output int                             results_owed
);

  import ntage_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     picked_id;
    logic                was_new;
    logic [OCNT_W-1:0]   removed_count;
    logic [OCNT_W-1:0]   entry_total;
  } table_result_t;

  logic [ID_W-1:0]   node_ids [TABLE_DEPTH];
  logic [TIME_W-1:0] heard_at [TABLE_DEPTH];
  int unsigned       live_count;
  logic [THR_W-1:0]  expiry_limit;
  table_result_t     owed_results[$];

  function automatic table_result_t apply_command(
    input logic [KIND_W-1:0] kind,
    input logic [ID_W-1:0]   id,
    input logic [TIME_W-1:0] now,
    input logic [RAND_W-1:0] rnd
  );
    table_result_t     res;
    logic [TIME_W-1:0] age;
    int unsigned       keep;
    bit                hit;
    res  = '0;
    keep = 0;
    hit  = 1'b0;
    case (kind)
      KIND_HEARD: begin
        res.picked_id = id;
        for (int i = 0; i < live_count; i++) begin
          if (!hit && node_ids[i] == id) begin
            heard_at[i] = now;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (live_count < TABLE_DEPTH) begin
            node_ids[live_count] = id;
            heard_at[live_count] = now;
            live_count++;
            res.was_new = 1'b1;
          end else begin
            res.status = STATUS_FULL;
          end
        end
      end
      KIND_SWEEP: begin
        for (int i = 0; i < live_count; i++) begin
          age = now - heard_at[i];
          if (age > expiry_limit) begin
            res.removed_count = res.removed_count + 1'b1;
          end else begin
            node_ids[keep] = node_ids[i];
            heard_at[keep] = heard_at[i];
            keep++;
          end
        end
        live_count = keep;
      end
      KIND_PICK: begin
        if (live_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.picked_id = node_ids[rnd % live_count];
        end
      end
      default: begin
      end
    endcase
    res.entry_total = live_count[OCNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      live_count     = 0;
      expiry_limit   = THRESHOLD_RESET;
      mismatch_count = 0;
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (cfg_wr_en) begin
        expiry_limit = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(apply_command(in_kind, in_node_id, in_now_seconds,
                                             in_random_value));
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with none outstanding, picked_id", out_picked_id, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_picked_id !== want.picked_id)
            report_mismatch("picked_id", out_picked_id, want.picked_id);
          if (out_was_new !== want.was_new)
            report_mismatch("was_new", out_was_new, want.was_new);
          if (out_removed_count !== want.removed_count)
            report_mismatch("removed_count", out_removed_count, want.removed_count);
          if (out_entry_total !== want.entry_total)
            report_mismatch("entry_total", out_entry_total, want.entry_total);
        end
      end
      results_owed <= owed_results.size();
    end
  end

endmodule

[tb/sv/tb_neighbour_table_aging_top.sv]
// ----------------------------------------------------------------------------
// Neighbour table aging testbench
// Drives heard, sweep, pick and idle transactions into the neighbour table,
// first a directed run through the empty, full and time wrap cases, then
// random phases under several expiry thresholds. The sender works in bursts
// and the receiver stalls on its own pattern; a separate check module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_neighbour_table_aging_top;

  import ntage_pkg::*;

  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam int RX_OPEN      = 0;
  localparam int RX_MOSTLY    = 1;
  localparam int RX_SPARSE    = 2;
  localparam int RX_LONG_STALL = 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [THR_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [ID_W-1:0]      in_node_id = '0;
  logic [TIME_W-1:0]    in_now_seconds = '0;
  logic [RAND_W-1:0]    in_random_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_picked_id;
  logic                 out_was_new;
  logic [OCNT_W-1:0]    out_removed_count;
  logic [OCNT_W-1:0]    out_entry_total;

  int                   mismatches;
  int                   owed;
  int                   burst_left = 0;
  int                   rx_mode = RX_OPEN;
  int                   rx_hold = 0;
  logic [TIME_W-1:0]    wall_clock;
  logic [ID_W-1:0]      id_pool [POOL_SIZE];

  always #2 clk = ~clk;

  neighbour_table_aging_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_node_id        (in_node_id),
    .in_now_seconds    (in_now_seconds),
    .in_random_value   (in_random_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_picked_id     (out_picked_id),
    .out_was_new       (out_was_new),
    .out_removed_count (out_removed_count),
    .out_entry_total   (out_entry_total)
  );

  neighbour_table_aging_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_node_id        (in_node_id),
    .in_now_seconds    (in_now_seconds),
    .in_random_value   (in_random_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_picked_id     (out_picked_id),
    .out_was_new       (out_was_new),
    .out_removed_count (out_removed_count),
    .out_entry_total   (out_entry_total),
    .mismatch_count    (mismatches),
    .results_owed      (owed)
  );

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_LONG_STALL);
      rx_hold <= $urandom_range(30, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  task automatic send_item(
    input logic [KIND_W-1:0] kind,
    input logic [ID_W-1:0]   id,
    input logic [TIME_W-1:0] now,
    input logic [RAND_W-1:0] rnd
  );
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_node_id      <= id;
    in_now_seconds  <= now;
    in_random_value <= rnd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (owed != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item;
    int                roll;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    roll = $urandom_range(0, 99);
    if (roll < 55)      kind = KIND_HEARD;
    else if (roll < 70) kind = KIND_SWEEP;
    else if (roll < 96) kind = KIND_PICK;
    else                kind = KIND_IDLE;
    if ($urandom_range(0, 39) == 0) wall_clock = $urandom();
    else                            wall_clock = wall_clock + $urandom_range(0, 4);
    id  = ($urandom_range(0, 6) != 0) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                      : ID_W'($urandom());
    now = wall_clock;
    roll = $urandom_range(0, 19);
    if (roll == 0)      now = wall_clock - $urandom_range(1, 300);
    else if (roll == 1) now = $urandom();
    if (kind != KIND_HEARD && kind != KIND_SWEEP) now = $urandom();
    if (kind != KIND_HEARD && $urandom_range(0, 1) == 0) id = ID_W'($urandom());
    send_item(kind, id, now, $urandom());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_PICK, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    send_item(KIND_SWEEP, 16'h0000, 32'h0, 32'h0);
    send_item(KIND_IDLE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_HEARD, 16'h0000, 32'h0, 32'h0);
    send_item(KIND_HEARD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_HEARD, 16'h0000, 32'd5, 32'h0);
    for (int n = 1; n <= 14; n++) begin
      send_item(KIND_HEARD, ID_W'(n), 32'd100, $urandom());
    end
    send_item(KIND_HEARD, 16'h1234, 32'd100, 32'h0);
    send_item(KIND_HEARD, 16'h0001, 32'd200, 32'h0);
    send_item(KIND_PICK, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    send_item(KIND_PICK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_SWEEP, 16'h0000, 32'd100, 32'h0);

    wall_clock = 32'd100;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       write_threshold(8'hFF);
        1:       write_threshold(8'h00);
        2:       write_threshold(THRESHOLD_RESET);
        default: write_threshold(THR_W'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < POOL_SIZE; i++) begin
        id_pool[i] = ID_W'($urandom());
      end
      if (phase == 3) wall_clock = 32'hFFFF_FFF0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
